>>> rtl/cpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_pkg: shared codes and types of the contiguous page allocator
// Page state codes, opcodes, status codes, fixed port widths and the
// result word passed from the controller to the output stage.
// ----------------------------------------------------------------------------
package cpa_pkg;

  // Fixed widths of the item and result fields
  localparam int OP_W   = 2;
  localparam int PG_W   = 10;
  localparam int KIND_W = 2;
  localparam int RUN_W  = 11;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 11;
  localparam int ST_W   = 2;

  // Page state codes as stored in the table
  localparam logic [ST_W-1:0] ST_USABLE   = 2'd0;
  localparam logic [ST_W-1:0] ST_KERNEL   = 2'd1;
  localparam logic [ST_W-1:0] ST_RESERVED = 2'd2;

  // Opcodes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_RUN    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_ARG   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 2'd3;

  // Page count register value after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PG_W-1:0]   first_page;
    logic [RUN_W-1:0]  pages_done;
  } cpa_result_t;

endpackage

>>> rtl/cpa_table_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_table_mem: page table storage
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module cpa_table_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 18
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/cpa_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_out_stage: result output register
// Hold one finished result for the output channel so the controller can
// take the next item while the result waits.
// ----------------------------------------------------------------------------
module cpa_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  cpa_pkg::cpa_result_t push_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cpa_pkg::cpa_result_t out_data
);

  assign push_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_valid && push_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      out_data <= push_data;
    end
  end

endmodule

>>> rtl/cpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_ctrl: allocator sequencer
// Clear the table after reset, then walk it one entry per cycle for
// first-fit search, run free and first-free refresh.
// ----------------------------------------------------------------------------
module cpa_ctrl #(
  parameter int MAX_PAGES = 1024,
  parameter int TAG_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [cpa_pkg::CFG_W-1:0]            pages_in_use,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic [cpa_pkg::OP_W-1:0]             opcode,
  input  logic [cpa_pkg::PG_W-1:0]             page_index,
  input  logic [cpa_pkg::KIND_W-1:0]           page_kind,
  input  logic [cpa_pkg::RUN_W-1:0]            run_pages,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output cpa_pkg::cpa_result_t                 res,
  output logic                                 mem_rd_en,
  output logic [$clog2(MAX_PAGES)-1:0]         mem_rd_addr,
  input  logic [TAG_BITS+cpa_pkg::ST_W-1:0]    mem_rd_data,
  output logic                                 mem_wr_en,
  output logic [$clog2(MAX_PAGES)-1:0]         mem_wr_addr,
  output logic [TAG_BITS+cpa_pkg::ST_W-1:0]    mem_wr_data
);

  localparam int IDX_W  = $clog2(MAX_PAGES);
  localparam int CNT_W  = ($clog2(MAX_PAGES + 1) > cpa_pkg::CFG_W) ?
                          $clog2(MAX_PAGES + 1) : cpa_pkg::CFG_W;
  localparam int WORD_W = TAG_BITS + cpa_pkg::ST_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD_WR,
    S_ALLOC_WALK,
    S_ALLOC_WR,
    S_FREE_WALK,
    S_SCAN,
    S_REPORT
  } state_t;

  state_t                     state;
  logic [CNT_W-1:0]           walk_addr;
  logic                       rd_pend;
  logic [CNT_W-1:0]           rd_idx;
  logic [CNT_W-1:0]           item_idx;
  logic [cpa_pkg::ST_W-1:0]   item_st;
  logic [CNT_W-1:0]           want;
  logic [CNT_W-1:0]           run;
  logic [CNT_W-1:0]           start;
  logic [CNT_W-1:0]           wr_ptr;
  logic [CNT_W-1:0]           wr_left;
  logic [CNT_W-1:0]           done_cnt;
  logic                       free_first;
  logic [TAG_BITS-1:0]        cur_tag;
  logic [TAG_BITS-1:0]        tag_counter;
  logic [CNT_W-1:0]           ffp;
  logic [cpa_pkg::STAT_W-1:0] res_status;
  logic [CNT_W-1:0]           res_first;
  logic [CNT_W-1:0]           res_done;

  logic [CNT_W-1:0]           page_cnt;
  logic [CNT_W-1:0]           cfg_ext;
  logic [CNT_W-1:0]           idx_in;
  logic [CNT_W-1:0]           want_in;
  logic [cpa_pkg::ST_W-1:0]   rd_st;
  logic [TAG_BITS-1:0]        rd_tag;
  logic                       pg_usable;
  logic                       pg_kernel;
  logic [CNT_W-1:0]           run_inc;
  logic [CNT_W-1:0]           start_now;
  logic [CNT_W-1:0]           done_inc;
  logic                       found_now;
  logic                       free_match;
  logic                       free_stop;
  logic                       scan_hit;
  logic                       walk_more;
  logic                       issue;
  logic [TAG_BITS-1:0]        tag_inc;
  logic [TAG_BITS-1:0]        tag_adv;

  assign cfg_ext  = CNT_W'(pages_in_use);
  assign page_cnt = (cfg_ext > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : cfg_ext;
  assign idx_in   = CNT_W'(page_index);
  assign want_in  = CNT_W'(run_pages);

  assign rd_st     = mem_rd_data[cpa_pkg::ST_W-1:0];
  assign rd_tag    = mem_rd_data[WORD_W-1:cpa_pkg::ST_W];
  assign pg_usable = (rd_st == cpa_pkg::ST_USABLE);
  assign pg_kernel = (rd_st == cpa_pkg::ST_KERNEL);
  assign run_inc   = run + CNT_W'(1);
  assign start_now = (run == '0) ? rd_idx : start;
  assign done_inc  = done_cnt + CNT_W'(1);
  assign walk_more = (walk_addr < page_cnt);

  assign found_now  = (state == S_ALLOC_WALK) && rd_pend && pg_usable && (run_inc == want);
  assign free_match = pg_kernel && (free_first ? (rd_tag != '0) : (rd_tag == cur_tag));
  assign free_stop  = (state == S_FREE_WALK) && rd_pend && !free_match;
  assign scan_hit   = (state == S_SCAN) && rd_pend && pg_usable;

  // Tag advance wraps and skips zero
  assign tag_inc = tag_counter + TAG_BITS'(1);
  assign tag_adv = (tag_inc == '0) ? TAG_BITS'(1) : tag_inc;

  always_comb begin
    unique case (state)
      S_ALLOC_WALK: issue = walk_more && !found_now;
      S_FREE_WALK:  issue = walk_more && !free_stop;
      S_SCAN:       issue = walk_more && !scan_hit;
      default:      issue = 1'b0;
    endcase
  end

  assign mem_rd_en   = issue;
  assign mem_rd_addr = walk_addr[IDX_W-1:0];

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = walk_addr[IDX_W-1:0];
    mem_wr_data = {{TAG_BITS{1'b0}}, cpa_pkg::ST_RESERVED};
    unique case (state)
      S_CLEAR: begin
        mem_wr_en = 1'b1;
      end
      S_LOAD_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = item_idx[IDX_W-1:0];
        mem_wr_data = {{TAG_BITS{1'b0}}, item_st};
      end
      S_ALLOC_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = wr_ptr[IDX_W-1:0];
        mem_wr_data = {cur_tag, cpa_pkg::ST_KERNEL};
      end
      S_FREE_WALK: begin
        mem_wr_en   = rd_pend && free_match;
        mem_wr_addr = rd_idx[IDX_W-1:0];
        mem_wr_data = {{TAG_BITS{1'b0}}, cpa_pkg::ST_USABLE};
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      walk_addr   <= '0;
      rd_pend     <= 1'b0;
      tag_counter <= TAG_BITS'(1);
      ffp         <= '0;
    end else begin
      rd_pend <= issue;
      if (issue) begin
        walk_addr <= walk_addr + CNT_W'(1);
        rd_idx    <= walk_addr;
      end
      unique case (state)
        S_CLEAR: begin
          walk_addr <= walk_addr + CNT_W'(1);
          if (walk_addr == CNT_W'(MAX_PAGES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            item_idx   <= idx_in;
            item_st    <= (page_kind > cpa_pkg::ST_RESERVED) ? cpa_pkg::ST_RESERVED : page_kind;
            want       <= want_in;
            res_first  <= '0;
            res_done   <= '0;
            res_status <= cpa_pkg::STAT_BAD_ARG;
            state      <= S_REPORT;
            unique case (opcode)
              cpa_pkg::OP_LOAD: begin
                if (idx_in < page_cnt) begin
                  state <= S_LOAD_WR;
                end
              end
              cpa_pkg::OP_ALLOC: begin
                if (want_in != '0) begin
                  if (ffp >= page_cnt) begin
                    res_status <= cpa_pkg::STAT_NO_RUN;
                  end else begin
                    walk_addr <= ffp;
                    run       <= '0;
                    state     <= S_ALLOC_WALK;
                  end
                end
              end
              cpa_pkg::OP_FREE: begin
                if (idx_in < page_cnt) begin
                  walk_addr  <= idx_in;
                  free_first <= 1'b1;
                  done_cnt   <= '0;
                  state      <= S_FREE_WALK;
                end
              end
              default: begin
                state <= S_REPORT;
              end
            endcase
          end
        end
        S_LOAD_WR: begin
          res_status <= cpa_pkg::STAT_OK;
          res_first  <= item_idx;
          walk_addr  <= '0;
          state      <= S_SCAN;
        end
        S_ALLOC_WALK: begin
          if (rd_pend) begin
            if (pg_usable) begin
              run <= run_inc;
              if (run == '0) begin
                start <= rd_idx;
              end
            end else begin
              run <= '0;
            end
          end
          if (found_now) begin
            tag_counter <= tag_adv;
            cur_tag     <= tag_adv;
            wr_ptr      <= start_now;
            wr_left     <= want;
            res_first   <= start_now;
            res_done    <= want;
            rd_pend     <= 1'b0;
            state       <= S_ALLOC_WR;
          end else if (!walk_more) begin
            res_status <= cpa_pkg::STAT_NO_RUN;
            rd_pend    <= 1'b0;
            state      <= S_REPORT;
          end
        end
        S_ALLOC_WR: begin
          wr_ptr  <= wr_ptr + CNT_W'(1);
          wr_left <= wr_left - CNT_W'(1);
          if (wr_left == CNT_W'(1)) begin
            res_status <= cpa_pkg::STAT_OK;
            walk_addr  <= '0;
            state      <= S_SCAN;
          end
        end
        S_FREE_WALK: begin
          if (rd_pend) begin
            if (free_match) begin
              free_first <= 1'b0;
              done_cnt   <= done_inc;
              if (free_first) begin
                cur_tag <= rd_tag;
              end
              if (!walk_more) begin
                res_status <= cpa_pkg::STAT_OK;
                res_first  <= item_idx;
                res_done   <= done_inc;
                walk_addr  <= '0;
                rd_pend    <= 1'b0;
                state      <= S_SCAN;
              end
            end else if (free_first) begin
              res_status <= cpa_pkg::STAT_NOT_ALLOC;
              rd_pend    <= 1'b0;
              state      <= S_REPORT;
            end else begin
              res_status <= cpa_pkg::STAT_OK;
              res_first  <= item_idx;
              res_done   <= done_cnt;
              walk_addr  <= '0;
              rd_pend    <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            ffp     <= rd_idx;
            rd_pend <= 1'b0;
            state   <= S_REPORT;
          end else if (!walk_more) begin
            ffp     <= page_cnt;
            rd_pend <= 1'b0;
            state   <= S_REPORT;
          end
        end
        S_REPORT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign item_stall     = (state != S_IDLE);
  assign res_valid      = (state == S_REPORT);
  assign res.status     = res_status;
  assign res.first_page = res_first[cpa_pkg::PG_W-1:0];
  assign res.pages_done = res_done[cpa_pkg::RUN_W-1:0];

  // A read and a write never hit the same entry in one cycle
  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
    else $error("page table read and write collide on one entry");

  // Item writes stay inside the present pages
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    (mem_wr_en && (state != S_CLEAR)) |-> (CNT_W'(mem_wr_addr) < page_cnt))
    else $error("page table write beyond page count");

  // The tag counter never holds the reserved zero tag
  a_tag_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |-> (tag_counter != '0))
    else $error("tag counter reached zero");

  // A found run leads straight into the write sweep with a fresh tag
  a_found_write: assert property (@(posedge clk) disable iff (rst)
    found_now |=> ((state == S_ALLOC_WR) && (cur_tag == tag_counter)))
    else $error("allocation did not start its write sweep");

endmodule

>>> rtl/contiguous_page_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_page_allocator_top: first-fit contiguous page allocator
// Page table with state and allocation tag per page, load, allocate and
// free items, one status result per item.
// ----------------------------------------------------------------------------
// The block keeps its page table in one synchronous RAM of MAX_PAGES entries
// and handles one item at a time; every table walk reads one entry per cycle
// through the single read port. After reset a clearing pass writes every
// entry as reserved with tag zero, with in_stall high; configuration writes
// are taken during it. A load writes its entry, then runs the first-free
// refresh. An allocate walks from the first free page, one page per cycle,
// until a fitting run is found or the page count is reached; for a found
// run it then writes each allocated page in turn and refreshes. A free
// walks the run from the given page and frees each of its pages in turn,
// then refreshes. The refresh scans from page zero to the first usable
// page (up to the page count). A finished result sits in an output
// register, so the next item can be taken while it waits.
module contiguous_page_allocator_top #(
  parameter int MAX_PAGES = 1024,
  parameter int TAG_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // item channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [cpa_pkg::OP_W-1:0]        opcode,
  input  logic [cpa_pkg::PG_W-1:0]        page_index,
  input  logic [cpa_pkg::KIND_W-1:0]      page_kind,
  input  logic [cpa_pkg::RUN_W-1:0]       run_pages,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cpa_pkg::STAT_W-1:0]      status,
  output logic [cpa_pkg::PG_W-1:0]        first_page,
  output logic [cpa_pkg::RUN_W-1:0]       pages_done,
  // page count register
  input  logic                            cfg_wr_en,
  input  logic [cpa_pkg::CFG_W-1:0]       cfg_wr_data
);

  localparam int IDX_W  = $clog2(MAX_PAGES);
  localparam int WORD_W = TAG_BITS + cpa_pkg::ST_W;

  logic [cpa_pkg::CFG_W-1:0] pages_in_use;

  logic                      mem_rd_en;
  logic [IDX_W-1:0]          mem_rd_addr;
  logic [WORD_W-1:0]         mem_rd_data;
  logic                      mem_wr_en;
  logic [IDX_W-1:0]          mem_wr_addr;
  logic [WORD_W-1:0]         mem_wr_data;

  logic                      res_valid;
  logic                      res_ready;
  cpa_pkg::cpa_result_t      res;
  cpa_pkg::cpa_result_t      out_res;

  // Page count register: write on every enabled transfer, values above the
  // table size act as the table size inside the controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= cpa_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      pages_in_use <= cfg_wr_data;
    end
  end

  // Page table: state in the low bits, allocation tag above it
  cpa_table_mem #(
    .DEPTH (MAX_PAGES),
    .WIDTH (WORD_W)
  ) u_table (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Sequencer: clearing pass, search, write sweep, free walk, refresh
  cpa_ctrl #(
    .MAX_PAGES (MAX_PAGES),
    .TAG_BITS  (TAG_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .pages_in_use (pages_in_use),
    .item_valid   (in_valid),
    .item_stall   (in_stall),
    .opcode       (opcode),
    .page_index   (page_index),
    .page_kind    (page_kind),
    .run_pages    (run_pages),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data)
  );

  // Output register: hold the result until the downstream transfer
  cpa_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .push_valid (res_valid),
    .push_ready (res_ready),
    .push_data  (res),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_res)
  );

  assign status     = out_res.status;
  assign first_page = out_res.first_page;
  assign pages_done = out_res.pages_done;

endmodule

>>> bench/page_table_shadow.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_shadow: result checker for the contiguous page allocator
// Watches the item, result and page count ports, keeps its own copy of the
// page table, works out the reply of every accepted item and compares each
// delivered result against the oldest reply still waiting.
// ----------------------------------------------------------------------------
module page_table_shadow #(
  parameter int MAX_PAGES = 1024,
  parameter int TAG_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [cpa_pkg::OP_W-1:0]        opcode,
  input  logic [cpa_pkg::PG_W-1:0]        page_index,
  input  logic [cpa_pkg::KIND_W-1:0]      page_kind,
  input  logic [cpa_pkg::RUN_W-1:0]       run_pages,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [cpa_pkg::STAT_W-1:0]      status,
  input  logic [cpa_pkg::PG_W-1:0]        first_page,
  input  logic [cpa_pkg::RUN_W-1:0]       pages_done,
  input  logic                            cfg_wr_en,
  input  logic [cpa_pkg::CFG_W-1:0]       cfg_wr_data,
  output int                              mismatches,
  output int                              pending
);
  import cpa_pkg::*;

  logic [ST_W-1:0]     page_state [MAX_PAGES];
  logic [TAG_BITS-1:0] page_tag   [MAX_PAGES];
  logic [TAG_BITS-1:0] last_tag;
  logic [CFG_W-1:0]    page_limit;
  int unsigned         first_usable;
  cpa_result_t         expected_replies [$];
  int                  error_total = 0;

  assign mismatches = error_total;

  function automatic int unsigned live_pages();
    return (page_limit > MAX_PAGES) ? MAX_PAGES : page_limit;
  endfunction

  task automatic rescan_first_usable();
    int unsigned i;
    i = 0;
    while (i < live_pages() && page_state[i] != ST_USABLE) i++;
    first_usable = i;
  endtask

  task automatic flag_mismatch(input string field, input int unsigned exp_val,
                               input int unsigned act_val);
    if (error_total < 100)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, act_val);
    error_total++;
  endtask

  // Apply one item to the shadow table and return the reply it must produce.
  task automatic apply_item(input logic [OP_W-1:0] op, input logic [PG_W-1:0] idx,
                            input logic [KIND_W-1:0] kind, input logic [RUN_W-1:0] want,
                            output cpa_result_t reply);
    int unsigned         n, i, run_len, run_start, freed;
    bit                  found;
    logic [TAG_BITS-1:0] tag;
    n = live_pages();
    reply = '{status: STAT_BAD_ARG, first_page: '0, pages_done: '0};
    run_len = 0;
    run_start = 0;
    found = 1'b0;
    case (op)
      OP_LOAD: begin
        if (idx < n) begin
          // the spare kind code lands as reserved
          page_state[idx] = (kind > ST_RESERVED) ? ST_RESERVED : kind;
          page_tag[idx] = '0;
          rescan_first_usable();
          reply = '{status: STAT_OK, first_page: idx, pages_done: '0};
        end
      end
      OP_ALLOC: begin
        if (want != 0) begin
          for (i = first_usable; i < n && !found; i++) begin
            if (page_state[i] == ST_USABLE) begin
              if (run_len == 0) run_start = i;
              run_len++;
              if (run_len == want) found = 1'b1;
            end else begin
              run_len = 0;
            end
          end
          if (!found) begin
            reply.status = STAT_NO_RUN;
          end else begin
            tag = last_tag + 1'b1;
            if (tag == '0) tag = 1;
            last_tag = tag;
            for (i = run_start; i < run_start + want; i++) begin
              page_state[i] = ST_KERNEL;
              page_tag[i] = tag;
            end
            rescan_first_usable();
            reply = '{status: STAT_OK, first_page: run_start[PG_W-1:0], pages_done: want};
          end
        end
      end
      OP_FREE: begin
        if (idx < n) begin
          tag = page_tag[idx];
          if (page_state[idx] != ST_KERNEL || tag == '0) begin
            reply.status = STAT_NOT_ALLOC;
          end else begin
            freed = 0;
            for (i = idx; i < n && page_state[i] == ST_KERNEL && page_tag[i] == tag; i++) begin
              page_state[i] = ST_USABLE;
              page_tag[i] = '0;
              freed++;
            end
            rescan_first_usable();
            reply = '{status: STAT_OK, first_page: idx, pages_done: freed[RUN_W-1:0]};
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    cpa_result_t predicted;
    cpa_result_t observed;
    int unsigned i;
    if (rst) begin
      for (i = 0; i < MAX_PAGES; i++) begin
        page_state[i] = ST_RESERVED;
        page_tag[i] = '0;
      end
      last_tag = 1;
      first_usable = 0;
      page_limit = CFG_RESET;
      expected_replies.delete();
    end else begin
      if (cfg_wr_en) page_limit = cfg_wr_data;
      // retire the delivered result before queuing a new reply
      if (out_valid && !out_stall) begin
        observed = '{status: status, first_page: first_page, pages_done: pages_done};
        if (expected_replies.size() == 0) begin
          if (error_total < 100)
            $display("%0t: result with nothing expected, got status %0d first_page %0d pages_done %0d",
                     $time, observed.status, observed.first_page, observed.pages_done);
          error_total++;
        end else begin
          predicted = expected_replies.pop_front();
          if (observed.status !== predicted.status)
            flag_mismatch("status", predicted.status, observed.status);
          if (observed.first_page !== predicted.first_page)
            flag_mismatch("first_page", predicted.first_page, observed.first_page);
          if (observed.pages_done !== predicted.pages_done)
            flag_mismatch("pages_done", predicted.pages_done, observed.pages_done);
        end
      end
      if (in_valid && !in_stall) begin
        apply_item(opcode, page_index, page_kind, run_pages, predicted);
        expected_replies.push_back(predicted);
      end
    end
    pending <= expected_replies.size();
  end

endmodule

>>> bench/tb_contiguous_page_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contiguous_page_allocator_top: stimulus and verdict for the allocator
// Runs a directed pass over the special cases at the full page count, then
// phases of random load, allocate and free items at a range of page counts,
// with bursty input traffic and a wandering result stall. The shadow table
// beside the block does all result checking.
// ----------------------------------------------------------------------------
module tb_contiguous_page_allocator_top;
  import cpa_pkg::*;

  localparam int MAX_PAGES    = 1024;
  localparam int TAG_BITS     = 16;
  // drain time for a refresh, a full walk and a full write, plus margin
  localparam int DRAIN_CYCLES = 3 * MAX_PAGES + 64;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // codes that the block must reject or fold
  localparam logic [OP_W-1:0]   OP_UNUSED  = 2'd3;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  logic              clk;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   opcode      = '0;
  logic [PG_W-1:0]   page_index  = '0;
  logic [KIND_W-1:0] page_kind   = '0;
  logic [RUN_W-1:0]  run_pages   = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [STAT_W-1:0] status;
  logic [PG_W-1:0]   first_page;
  logic [RUN_W-1:0]  pages_done;
  logic              cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;

  int          mismatches;
  int          pending;
  int          burst_left  = 0;
  int          stall_mode  = 0;
  int          mode_left   = 0;
  int          stall_run   = 0;
  int unsigned cycle_count = 0;

  contiguous_page_allocator_top #(
    .MAX_PAGES(MAX_PAGES),
    .TAG_BITS (TAG_BITS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .page_index (page_index),
    .page_kind  (page_kind),
    .run_pages  (run_pages),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .first_page (first_page),
    .pages_done (pages_done),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Shadow table: predicts every reply and checks the result channel.
  page_table_shadow #(
    .MAX_PAGES(MAX_PAGES),
    .TAG_BITS (TAG_BITS)
  ) shadow (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .page_index (page_index),
    .page_kind  (page_kind),
    .run_pages  (run_pages),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .first_page (first_page),
    .pages_done (pages_done),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Result stall: switch at random among free flow, random stalls, long stall
  // runs and a strict toggle. None of it looks at out_valid.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: begin
        if (stall_run == 0) begin
          out_stall <= !out_stall;
          stall_run <= $urandom_range(1, 20);
        end else begin
          stall_run <= stall_run - 1;
        end
      end
      default: out_stall <= !out_stall;
    endcase
  end

  // Watchdog: end the run as failed once the cycle limit is reached.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("contiguous_page_allocator_top test failed");
      $finish;
    end
  end

  // Present one item and hold it until its transfer. Items come in bursts;
  // between bursts drop valid for a random gap, or chain straight into the
  // next burst. Valid stays high on return so a following item can ride
  // the same edge; callers that stop sending must lower it themselves.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [PG_W-1:0] idx,
                           input logic [KIND_W-1:0] kind, input logic [RUN_W-1:0] want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    page_index <= idx;
    page_kind  <= kind;
    run_pages  <= want;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // Write the page count once the block has answered everything sent.
  task automatic set_page_count(input logic [CFG_W-1:0] count);
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One random item over a table of span pages: mostly in-range indexes and
  // small runs, with out-of-range indexes, oversize and zero runs and the
  // unused opcode mixed in. Unused fields carry random bits.
  task automatic random_item(input int unsigned span);
    logic [OP_W-1:0]   op;
    logic [PG_W-1:0]   idx;
    logic [KIND_W-1:0] kind;
    logic [RUN_W-1:0]  want;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    kind = $urandom;
    want = $urandom;
    idx  = (span == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_PAGES - 1)
                                                    : $urandom_range(0, span - 1);
    if (pick < 25) begin
      op = OP_LOAD;
      if ($urandom_range(0, 2) != 0) kind = ST_USABLE;
    end else if (pick < 60) begin
      op = OP_ALLOC;
      case ($urandom_range(0, 19))
        0:       want = '0;
        1:       want = $urandom_range(0, 2047);
        2:       want = span;
        default: want = $urandom_range(1, span / 3 + 1);
      endcase
    end else if (pick < 96) begin
      op = OP_FREE;
    end else begin
      op = OP_UNUSED;
    end
    send_item(op, idx, kind, want);
  endtask

  initial begin
    int unsigned p, k, pages, items, span;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed pass at the reset page count of 1024.
    send_item(OP_LOAD,  MAX_PAGES - 1, ST_USABLE,  '0);    // last page usable
    send_item(OP_LOAD,  '0,            KIND_SPARE, '0);    // spare kind folds to reserved
    send_item(OP_ALLOC, '1,            '1,         '0);    // zero-size allocate
    send_item(OP_ALLOC, '0,            '0,         '1);    // size far above the table
    send_item(OP_ALLOC, '0,            '0,         1);     // takes the last page
    send_item(OP_FREE,  MAX_PAGES - 1, '0,         '0);    // free stops at table end
    send_item(OP_FREE,  MAX_PAGES - 1, '0,         '0);    // already usable
    send_item(OP_UNUSED, '1,           '1,         '1);    // unknown opcode
    send_item(OP_LOAD,  5,             ST_USABLE,  '0);
    send_item(OP_LOAD,  6,             ST_USABLE,  '0);
    send_item(OP_LOAD,  7,             ST_KERNEL,  '0);    // kernel page with no tag
    send_item(OP_LOAD,  8,             ST_USABLE,  '0);
    send_item(OP_LOAD,  9,             ST_USABLE,  '0);
    send_item(OP_LOAD,  10,            ST_USABLE,  '0);
    send_item(OP_ALLOC, '0,            '0,         3);     // run restarts after page 7
    send_item(OP_ALLOC, '0,            '0,         2);     // first fit at page 5
    send_item(OP_FREE,  7,             '0,         '0);    // kernel, tag zero
    send_item(OP_FREE,  9,             '0,         '0);    // tail of a run
    send_item(OP_FREE,  5,             '0,         '0);    // stops at the untagged page
    send_item(OP_LOAD,  MAX_PAGES - 1, ST_RESERVED, '0);
    send_item(OP_ALLOC, '0,            '0,         MAX_PAGES); // whole table, no fit

    // Random phases. Keep most page counts small so each walk stays short;
    // visit the extremes, an empty table and an oversize count briefly.
    for (p = 0; p < 11; p++) begin
      case (p)
        0:       begin pages = 16;   items = 60;  end
        1:       begin pages = 1;    items = 15;  end
        2:       begin pages = 37;   items = 80;  end
        3:       begin pages = 0;    items = 6;   end
        4:       begin pages = 64;   items = 90;  end
        5:       begin pages = 2047; items = 8;   end
        6:       begin pages = 23;   items = 80;  end
        7:       begin pages = 48;   items = 100; end
        8:       begin pages = 1024; items = 10;  end
        9:       begin pages = 31;   items = 80;  end
        default: begin pages = 8;    items = 50;  end
      endcase
      set_page_count(pages[CFG_W-1:0]);
      span = (pages > MAX_PAGES) ? MAX_PAGES : pages;
      // seed small tables with mostly usable pages so allocations can land
      if (span <= 64) begin
        for (k = 0; k < span; k++)
          send_item(OP_LOAD, k[PG_W-1:0],
                    ($urandom_range(0, 6) == 0) ? $urandom_range(0, 3) : ST_USABLE,
                    $urandom);
      end
      for (k = 0; k < items; k++) random_item(span);
    end

    // Drain: stop sending, wait for every reply, then give stray results time.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("contiguous_page_allocator_top test passed");
    end else begin
      $display("contiguous_page_allocator_top test failed");
    end
    $finish;
  end

endmodule
